FILE: rtl/lir_pkg.sv
// shared types and constants of the linear interpolating resampler
package lir_pkg;

    localparam int STEP_BITS      = 20;
    localparam int START_BITS     = 16;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int COUNT_BITS     = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_RATIO  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_PHASE = 2'd1;

    localparam logic [STEP_BITS-1:0]  STEP_RESET  = 20'd65536;
    localparam logic [COUNT_BITS-1:0] MAX_RESULTS = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic step;
        logic emit;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic phase_ge_one;
        logic last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/lir_ctrl.sv
// run controller of the linear interpolating resampler
module lir_ctrl
    import lir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                // only the first check of a run can see the phase at or past one
                if (i_stat.phase_ge_one) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/lir_dp.sv
// sample, phase and interpolation datapath of the resampler
module lir_dp
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_last_of_run
);

    localparam int PHASE_BITS = FRAC_BITS + 4;
    localparam int SUM_BITS   = ((PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS) + 1;
    localparam int DIFF_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS  = DIFF_BITS + FRAC_BITS + 1;

    localparam logic [PHASE_BITS-1:0] PHASE_ONE  = PHASE_BITS'(1) << FRAC_BITS;
    localparam logic [PHASE_BITS-1:0] PHASE_MAX  = '1;
    localparam logic [PHASE_BITS-1:0] FRAC_MASK  = PHASE_ONE - PHASE_BITS'(1);

    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [DIFF_BITS-1:0]   r_diff;
    logic [PHASE_BITS-1:0]         r_phase;
    logic [STEP_BITS-1:0]          r_step;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic                          r_last;
    logic [COUNT_BITS-1:0]         r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_last;
    logic                          r_out_valid;

    logic [SUM_BITS-1:0]           w_sum;
    logic [PHASE_BITS-1:0]         w_phase_next;
    logic [COUNT_BITS-1:0]         w_cnt_inc;
    logic signed [FRAC_BITS:0]     w_frac_s;
    logic signed [PROD_BITS-1:0]   w_shift;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic [START_BITS-1:0]         w_start;
    logic                          w_phase_ge_one;

    assign w_sum        = SUM_BITS'(r_phase) + SUM_BITS'(r_step);
    // the accumulator saturates instead of wrapping
    assign w_phase_next = (w_sum > SUM_BITS'(PHASE_MAX)) ? PHASE_MAX : PHASE_BITS'(w_sum);
    assign w_cnt_inc    = r_cnt + COUNT_BITS'(1);
    assign w_frac_s     = {1'b0, r_phase[FRAC_BITS-1:0]};
    // arithmetic shift gives the floor toward minus infinity
    assign w_shift      = r_prod >>> FRAC_BITS;
    assign w_y          = w_shift[SAMPLE_BITS-1:0] + r_prev;
    assign w_start      = i_cfg_data[START_BITS-1:0];
    assign w_phase_ge_one = (r_phase >= PHASE_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_phase     <= '0;
            r_step      <= STEP_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_STEP_RATIO)) begin
                r_step <= i_cfg_data[STEP_BITS-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_START_PHASE)) begin
                r_phase <= PHASE_BITS'(w_start) & FRAC_MASK;
            end
            if (i_cmd.step) begin
                r_phase <= w_phase_next;
                r_cnt   <= w_cnt_inc;
            end
            if (i_cmd.finish) begin
                // a run cut short below one keeps its phase
                if (w_phase_ge_one) begin
                    r_phase <= r_phase - PHASE_ONE;
                end
                r_prev <= r_x;
                r_cnt  <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x    <= i_in_sample;
            r_diff <= DIFF_BITS'(i_in_sample) - DIFF_BITS'(r_prev);
        end
        if (i_cmd.step) begin
            r_prod <= r_diff * w_frac_s;
            r_last <= (w_phase_next >= PHASE_ONE) || (w_cnt_inc == MAX_RESULTS);
        end
        if (i_cmd.emit) begin
            r_out_sample <= w_y;
            r_out_last   <= r_last;
        end
    end

    assign o_stat.phase_ge_one = w_phase_ge_one;
    assign o_stat.last         = r_last;
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_sample  = r_out_sample;
    assign o_last_of_run = r_out_last;

endmodule

FILE: rtl/linear_interpolating_resampler_core.sv
// Linear interpolating resampler: each input transaction carries one signed sample and
// causes zero to 64 output transactions, each prev + floor((x - prev) * phase / 2^FRAC_BITS)
// while the Q.FRAC_BITS phase is below one, the phase advancing by step_ratio per output.
// Each output passes through the multiply register and then the output register, and a
// stalled output register holds the run until the output is taken. The next input is taken
// while the final output of a run still waits to be taken. Configuration writes go through
// i_cfg_we, i_cfg_index (0 step_ratio, 1 start_phase, others ignored) and i_cfg_data; the
// user must make them only while idle, which the block itself does not enforce; a
// start_phase write loads the phase accumulator.
module linear_interpolating_resampler_core
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    lir_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_sample   (i_in_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_sample  (o_out_sample),
        .o_last_of_run (o_last_of_run)
    );

endmodule

FILE: rtl/lir_checker.sv
// port level checks of the resampler core and their bind
module lir_checker
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] o_out_sample,
    input logic                   o_last_of_run
);

    // a pending output transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped before the transaction");

    // a pending output transaction keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_out_valid && !i_out_ready) |=> ($stable(o_out_sample)
            && $stable(o_last_of_run)))
        else $error("output payload changed while stalled");

    // one item at a time: ready drops right after an input transaction
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a run is in progress");

    // a new output only comes out of a run, never straight from idle
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $rose(o_out_valid)) |-> $past(!o_in_ready))
        else $error("output appeared without a run in progress");

endmodule

bind linear_interpolating_resampler_core lir_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_sample  (o_out_sample),
    .o_last_of_run (o_last_of_run)
);
